@@ rtl/cshit_pkg.sv @@
// cshit_pkg: shared constants and the arctangent table function for the circle/sector hit test
// no dependencies
`timescale 1ns / 1ps
package cshit_pkg;
  // result reason codes
  localparam logic [1:0] DEC_RANGE  = 2'd0;
  localparam logic [1:0] DEC_INSIDE = 2'd1;
  localparam logic [1:0] DEC_AHIT   = 2'd2;
  localparam logic [1:0] DEC_AMISS  = 2'd3;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
        5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
        5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
        5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
        5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
        5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
        5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
        5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      return v;
    end
  endfunction
endpackage

@@ rtl/circle_sector_hit_test_top.sv @@
// circle_sector_hit_test_top: pipelined circle versus sector hit test
// depends on cshit_pkg, cshit_root, cshit_cordic
//
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_<field>
// out     | output    | out_valid, out_stall, out_hit, out_decided_by
//
// one word per cycle while out_stall does not hold the pipeline; the stages are
// two input stages, the root stages, cordic prefold and stages, output register.
// the whole pipeline advances together; out_stall freezes every stage.
// in_stall follows out_stall only when the output register holds a word.
// rst_n clears the valid bits only.
`timescale 1ns / 1ps
module circle_sector_hit_test_top #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_circle_x,
  input  logic signed [COORD_BITS-1:0] in_circle_y,
  input  logic [COORD_BITS-2:0]        in_circle_radius,
  input  logic signed [COORD_BITS-1:0] in_sector_x,
  input  logic signed [COORD_BITS-1:0] in_sector_y,
  input  logic [COORD_BITS-2:0]        in_sector_radius,
  input  logic [ANGLE_BITS-1:0]        in_sector_direction,
  input  logic [ANGLE_BITS-1:0]        in_sector_width,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [1:0]                   out_decided_by
);
  localparam int DB  = COORD_BITS + 1;          // dx, dy width
  localparam int QB  = 2 * DB + 16;             // squared distance scaled by 2^16
  localparam int RB  = QB / 2 + 1;              // root width
  localparam int CRB = COORD_BITS - 1;
  localparam int NS  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int VB  = DB + 8 + 16 + 4;         // cordic datapath width
  localparam int LAT = 2 + QB / 2 + 1 + NS + 1;

  logic en;
  logic [LAT-1:0] vld_r;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: offsets
  logic signed [DB-1:0] dx_r, dy_r;
  logic [CRB-1:0] cr_r, sr_r;
  logic [ANGLE_BITS-1:0] dir_r, wid_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DB'(in_circle_x) - DB'(in_sector_x);
      dy_r <= DB'(in_circle_y) - DB'(in_sector_y);
      cr_r <= in_circle_radius; sr_r <= in_sector_radius;
      dir_r <= in_sector_direction; wid_r <= in_sector_width;
    end
  end

  // stage 2: squares
  logic [2*DB-1:0] d2_r, l2_r;
  logic [CRB-1:0] cr2_r, sr2_r;
  logic signed [DB-1:0] dx2_r, dy2_r;
  logic [ANGLE_BITS-1:0] dir2_r, wid2_r;
  logic [2*DB-1:0] d2_nxt, c2_nxt;
  assign d2_nxt = (2*DB)'(dx_r * dx_r) + (2*DB)'(dy_r * dy_r);
  assign c2_nxt = (2*DB)'(cr_r) * (2*DB)'(cr_r);
  always_ff @(posedge clk) begin
    if (en) begin
      d2_r <= d2_nxt;
      l2_r <= (d2_nxt > c2_nxt) ? d2_nxt - c2_nxt : '0;
      cr2_r <= cr_r; sr2_r <= sr_r; dx2_r <= dx_r; dy2_r <= dy_r;
      dir2_r <= dir_r; wid2_r <= wid_r;
    end
  end

  // roots of distance and tangent leg
  localparam int XB = 2 * DB + 2 * ANGLE_BITS + 2 * CRB;
  logic [RB-1:0] dist8, leg8;
  logic [XB-1:0] side_in, side_out, side_unused;
  assign side_in = {dx2_r, dy2_r, dir2_r, wid2_r, cr2_r, sr2_r};
  cshit_root #(.NB(QB), .SB(XB)) u_dist (
    .clk(clk), .en(en), .op({d2_r, 16'd0}), .side_in(side_in),
    .root(dist8), .side_out(side_out));
  cshit_root #(.NB(QB), .SB(XB)) u_leg (
    .clk(clk), .en(en), .op({l2_r, 16'd0}), .side_in(side_in),
    .root(leg8), .side_out(side_unused));

  logic signed [DB-1:0] rdx, rdy;
  logic [ANGLE_BITS-1:0] rdir, rwid;
  logic [CRB-1:0] rcr, rsr;
  assign {rdx, rdy, rdir, rwid, rcr, rsr} = side_out;

  // early decision and cordic inputs
  logic [1:0] early;
  logic [RB-1:0] crs, sum8;
  assign crs  = RB'(rcr) << 8;
  assign sum8 = (RB'(rcr) + RB'(rsr)) << 8;
  always_comb begin
    if (dist8 > sum8) early = cshit_pkg::DEC_RANGE;
    else if (dist8 < crs) early = cshit_pkg::DEC_INSIDE;
    else if (dist8 == '0) early = cshit_pkg::DEC_AMISS;
    else early = cshit_pkg::DEC_AHIT;   // angle test pending
  end

  logic [ANGLE_BITS-1:0] bearing, widen;
  cshit_cordic #(.VB(VB), .STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_brg (
    .clk(clk), .en(en), .x_in(VB'(rdx) <<< 8), .y_in(-(VB'(rdy) <<< 8)), .angle(bearing));
  cshit_cordic #(.VB(VB), .STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_wid (
    .clk(clk), .en(en), .x_in(VB'(leg8)), .y_in(VB'(crs)), .angle(widen));

  // delay line for the early decision and angle operands
  logic [1:0] ed_r [NS+1];
  logic [ANGLE_BITS-1:0] dd_r [NS+1];
  logic [ANGLE_BITS-1:0] wd_r [NS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      ed_r[0] <= early; dd_r[0] <= rdir; wd_r[0] <= rwid;
      for (int i = 0; i < NS; i++) begin
        ed_r[i+1] <= ed_r[i]; dd_r[i+1] <= dd_r[i]; wd_r[i+1] <= wd_r[i];
      end
    end
  end
  logic [1:0] ed; logic [ANGLE_BITS-1:0] dd, wd;
  assign ed = ed_r[NS]; assign dd = dd_r[NS]; assign wd = wd_r[NS];

  // angle compare
  logic [ANGLE_BITS-1:0] diff, fold;
  logic ang_hit;
  assign diff = bearing - dd;
  assign fold = (diff > (ANGLE_BITS'(1) << (ANGLE_BITS - 1))) ? -diff : diff;
  assign ang_hit = ((ANGLE_BITS+2)'(fold) << 1) <
                   ((ANGLE_BITS+2)'(wd) + ((ANGLE_BITS+2)'(widen) << 1));

  // output register
  logic [1:0] dec_nxt;
  assign dec_nxt = (ed == cshit_pkg::DEC_AHIT) ?
                   (ang_hit ? cshit_pkg::DEC_AHIT : cshit_pkg::DEC_AMISS) : ed;
  logic [1:0] dec_r;
  always_ff @(posedge clk) begin
    if (en) dec_r <= dec_nxt;
  end
  assign out_decided_by = dec_r;
  assign out_hit = (dec_r == cshit_pkg::DEC_INSIDE) || (dec_r == cshit_pkg::DEC_AHIT);

  // valid bits march with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
  end
  assign out_valid = vld_r[LAT-1];
endmodule

@@ rtl/cshit_root.sv @@
// cshit_root: pipelined rounded square root, one result bit per stage
// depends on nothing; sideband word travels with the operand
`timescale 1ns / 1ps
module cshit_root #(
  parameter int NB = 48,
  parameter int SB = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] op,
  input  logic [SB-1:0] side_in,
  output logic [NB/2:0] root,
  output logic [SB-1:0] side_out
);
  localparam int RB = NB / 2;
  logic [NB-1:0] rem_r [RB+1];
  logic [NB-1:0] res_r [RB+1];
  logic [SB-1:0] sd_r  [RB+1];

  always_comb begin
    rem_r[0] = op;
    res_r[0] = '0;
    sd_r[0]  = side_in;
  end

  // classic digit-by-digit root, bit = 4^(RB-1-k)
  for (genvar k = 0; k < RB; k++) begin : g_st
    localparam logic [NB-1:0] BIT = NB'(1) << (2 * (RB - 1 - k));
    logic [NB-1:0] rem_nxt, res_nxt;
    always_comb begin
      if (rem_r[k] >= res_r[k] + BIT) begin
        rem_nxt = rem_r[k] - (res_r[k] + BIT);
        res_nxt = (res_r[k] >> 1) + BIT;
      end else begin
        rem_nxt = rem_r[k];
        res_nxt = res_r[k] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        res_r[k+1] <= res_nxt;
        sd_r[k+1]  <= sd_r[k];
      end
    end
  end

  // round up when the remainder exceeds the root
  assign root = (rem_r[RB] > res_r[RB]) ? (RB+1)'(res_r[RB]) + 1'b1 : (RB+1)'(res_r[RB]);
  assign side_out = sd_r[RB];
endmodule

@@ rtl/cshit_cordic.sv @@
// cshit_cordic: pipelined vectoring CORDIC, returns rounded binary angle
// depends on cshit_pkg for the arctangent table
`timescale 1ns / 1ps
module cshit_cordic #(
  parameter int VB = 60,
  parameter int STAGES = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [VB-1:0]   x_in,
  input  logic signed [VB-1:0]   y_in,
  output logic [ANGLE_BITS-1:0]  angle
);
  localparam int NS = (STAGES < 24) ? STAGES : 24;
  logic signed [VB-1:0] x_r [NS+1];
  logic signed [VB-1:0] y_r [NS+1];
  logic [31:0]          z_r [NS+1];

  // half-turn prefold and scale by 2^16
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        x_r[0] <= (-x_in) <<< 16;
        y_r[0] <= (-y_in) <<< 16;
        z_r[0] <= 32'h80000000;
      end else begin
        x_r[0] <= x_in <<< 16;
        y_r[0] <= y_in <<< 16;
        z_r[0] <= 32'h0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + cshit_pkg::atan_turn(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - cshit_pkg::atan_turn(5'(i));
        end
      end
    end
  end

  logic [31:0] zr;
  assign zr = z_r[NS] + (32'd1 << (31 - ANGLE_BITS));
  assign angle = zr[31 -: ANGLE_BITS];
endmodule

@@ rtl/cshit_check.sv @@
// cshit_check: port-level checks for circle_sector_hit_test_top
// bound to the top level below
`timescale 1ns / 1ps
module cshit_check (
  input logic clk, rst_n, in_valid, in_stall, out_valid, out_stall,
  input logic out_hit,
  input logic [1:0] out_decided_by
);
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit == (out_decided_by == cshit_pkg::DEC_INSIDE ||
                              out_decided_by == cshit_pkg::DEC_AHIT)) else $error("hit");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall) else $error("stall");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_decided_by)) else $error("hold");
  // a stalled input word stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("in hold");
endmodule

bind circle_sector_hit_test_top cshit_check u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
  .out_decided_by(out_decided_by));

@@ tb/tb_circle_sector_hit_test_top.sv @@
// tb_circle_sector_hit_test_top: self-checking bench for the circle/sector hit test
// depends on cshit_pkg and circle_sector_hit_test_top
`timescale 1ns / 1ps
module tb_circle_sector_hit_test_top;

  localparam int LATENCY = 2 + 25 + 17 + 1;
  localparam int N_RANDOM = 1530;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        cr;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [14:0]        sr;
    logic [15:0]        dir;
    logic [15:0]        wid;
  } pair_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] dec;
  } verdict_t;

  typedef struct packed {
    pair_t    p;
    logic     known;
    verdict_t v;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pair_t in_p = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [1:0] out_decided_by;

  verdict_t verdict_q[$];
  int err_count = 0;
  bit no_idle = 1'b0;

  circle_sector_hit_test_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_circle_x(in_p.cx), .in_circle_y(in_p.cy), .in_circle_radius(in_p.cr),
    .in_sector_x(in_p.sx), .in_sector_y(in_p.sy), .in_sector_radius(in_p.sr),
    .in_sector_direction(in_p.dir), .in_sector_width(in_p.wid),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_decided_by(out_decided_by)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // rounded integer square root, ties up
  function automatic longint unsigned root_near(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r = r + 1;
    return r;
  endfunction

  // vectoring cordic, binary angle of (x, y)
  function automatic logic [15:0] bin_angle(longint x, longint y);
    logic [31:0] z;
    logic [32:0] zr;
    longint xs, ys;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + cshit_pkg::atan_turn(i[4:0]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - cshit_pkg::atan_turn(i[4:0]);
      end
    end
    zr = {1'b0, z} + 33'h8000;
    return zr[31:16];
  endfunction

  // expected verdict for one circle/sector pair
  function automatic verdict_t hit_verdict(pair_t p);
    longint dx, dy, cr, sr, d2, cr2;
    longint unsigned dist8, leg8;
    logic [15:0] bearing, widen, diff;
    verdict_t v;
    dx = longint'(p.cx) - longint'(p.sx);
    dy = longint'(p.cy) - longint'(p.sy);
    cr = longint'(p.cr);
    sr = longint'(p.sr);
    d2 = dx * dx + dy * dy;
    dist8 = root_near(d2 << 16);
    if (dist8 > ((sr + cr) << 8)) begin
      v.hit = 1'b0; v.dec = cshit_pkg::DEC_RANGE;
    end else if (dist8 < (cr << 8)) begin
      v.hit = 1'b1; v.dec = cshit_pkg::DEC_INSIDE;
    end else if (dist8 == 0) begin
      v.hit = 1'b0; v.dec = cshit_pkg::DEC_AMISS;
    end else begin
      bearing = bin_angle(dx * 256, -dy * 256);
      cr2 = cr * cr;
      leg8 = (d2 > cr2) ? root_near((d2 - cr2) << 16) : 0;
      widen = bin_angle(longint'(leg8), cr << 8);
      diff = bearing - p.dir;
      if (diff > 16'h8000) diff = 16'h0 - diff;
      if (2 * longint'(diff) < longint'(p.wid) + 2 * longint'(widen)) begin
        v.hit = 1'b1; v.dec = cshit_pkg::DEC_AHIT;
      end else begin
        v.hit = 1'b0; v.dec = cshit_pkg::DEC_AMISS;
      end
    end
    return v;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random pair, mostly close enough to reach the angle test
  function automatic pair_t rand_pair();
    pair_t p;
    int k, span;
    k = $urandom_range(0, 7);
    p.cx = 16'($urandom); p.cy = 16'($urandom); p.sx = 16'($urandom); p.sy = 16'($urandom);
    p.cr = 15'($urandom); p.sr = 15'($urandom); p.dir = 16'($urandom); p.wid = 16'($urandom);
    if (k != 0) begin
      span = (k < 4) ? 64 : (k < 7) ? 2000 : 30000;
      p.sx = p.cx - 16'(int'($urandom_range(0, 2 * span)) - span);
      p.sy = p.cy - 16'(int'($urandom_range(0, 2 * span)) - span);
      p.cr = 15'($urandom_range(0, span / 2));
      p.sr = 15'($urandom_range(0, 2 * span));
    end
    return p;
  endfunction

  // offer one word, hold until accepted, then idle
  task automatic send_word(pair_t p, bit known, verdict_t v);
    int gap;
    in_p <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict_q.push_back(known ? v : hit_verdict(p));
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // directed rows: expected typed in where obvious
  row_t rows[] = '{
    '{'{16'sd0, 16'sd0, 15'd0, 16'sd0, 16'sd0, 15'd0, 16'd0, 16'd0},
      1'b1, '{1'b0, cshit_pkg::DEC_AMISS}},
    '{'{-16'sd32768, -16'sd32768, 15'd0, 16'sd32767, 16'sd32767, 15'd0, 16'd0, 16'hFFFF},
      1'b1, '{1'b0, cshit_pkg::DEC_RANGE}},
    '{'{16'sd32767, 16'sd32767, 15'd0, -16'sd32768, -16'sd32768, 15'd0, 16'hFFFF, 16'hFFFF},
      1'b1, '{1'b0, cshit_pkg::DEC_RANGE}},
    '{'{16'sd100, 16'sd100, 15'd5, 16'sd100, 16'sd100, 15'd0, 16'd0, 16'd0},
      1'b1, '{1'b1, cshit_pkg::DEC_INSIDE}},
    '{'{-16'sd32768, 16'sd32767, 15'h7FFF, -16'sd32768, 16'sd32767, 15'h7FFF, 16'hFFFF, 16'd0},
      1'b1, '{1'b1, cshit_pkg::DEC_INSIDE}},
    '{'{16'sd32767, 16'sd0, 15'h7FFF, -16'sd32768, 16'sd0, 15'h7FFF, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'sd10, 16'sd0, 15'd0, 16'sd0, 16'sd0, 15'd20, 16'd0, 16'd2}, 1'b0, '0},
    '{'{16'sd0, -16'sd10, 15'd0, 16'sd0, 16'sd0, 15'd20, 16'h4000, 16'd100}, 1'b0, '0},
    '{'{-16'sd10, 16'sd0, 15'd0, 16'sd0, 16'sd0, 15'd20, 16'd0, 16'hFFFF}, 1'b0, '0},
    '{'{-16'sd10, 16'sd0, 15'd0, 16'sd0, 16'sd0, 15'd20, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd10, 15'd3, 16'sd0, 16'sd0, 15'd10, 16'h4000, 16'd0}, 1'b0, '0},
    '{'{16'sd3, 16'sd4, 15'd5, 16'sd0, 16'sd0, 15'd0, 16'h8000, 16'd0}, 1'b0, '0},
    '{'{16'sd3, 16'sd4, 15'd5, 16'sd0, 16'sd0, 15'd0, 16'hC000, 16'd0}, 1'b0, '0},
    '{'{16'sd7, -16'sd7, 15'd2, 16'sd0, 16'sd0, 15'd10, 16'h2000, 16'h0800}, 1'b0, '0},
    '{'{16'sd1000, 16'sd1000, 15'd10, 16'sd0, 16'sd0, 15'h7FFF, 16'hE000, 16'h1000}, 1'b0, '0},
    '{'{16'sd1, 16'sd0, 15'd1, 16'sd0, 16'sd0, 15'd0, 16'h8000, 16'd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 15'd0, 16'sd0, 16'sd0, 15'h7FFF, 16'hFFFF, 16'hFFFF},
      1'b1, '{1'b0, cshit_pkg::DEC_AMISS}}
  };

  // stimulus and end of run
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_word(rows[i].p, rows[i].known, rows[i].v);
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 600 && i < 800);
      send_word(rand_pair(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: compare each accepted word, then pick the next stall
  int stall_left = 0;
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected word: hit %0d decided_by %0d", out_hit, out_decided_by);
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit expected %0d actual %0d", want.hit, out_hit);
          err_count++;
        end
        if (out_decided_by !== want.dec) begin
          $error("decided_by expected %0d actual %0d", want.dec, out_decided_by);
          err_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // watchdog
  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
